[rtl/core/rim_pkg.sv]
package rim_pkg;

   localparam int unsigned DEF_MAX_AXIS_LEN = 256;
   localparam int unsigned DEF_MAX_REPEAT   = 64;
   localparam int unsigned DEF_NUM_DIMS     = 4;
   localparam int unsigned DEF_ADDR_WIDTH   = 32;

   localparam int unsigned SIZE_W    = 13;
   localparam int unsigned AXIS_W    = 2;
   localparam int unsigned ENTRY_W   = 8;
   localparam int unsigned CNT_W     = 7;
   localparam int unsigned OFS_W     = 15;
   localparam int unsigned FIELD_W   = 32;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_DIM0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_DIM1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_DIM2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_DIM3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_AXIS = 3'd4;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_MAP  = 1'b1;

   typedef struct packed {
      logic [3:0][SIZE_W-1:0] size;
      logic [AXIS_W-1:0]      axis;
   } cfg_type;

   typedef struct packed {
      logic [FIELD_W-1:0] base;
      logic [FIELD_W-1:0] stride;
      logic [CNT_W-1:0]   count;
      logic [FIELD_W-1:0] source;
      logic               err;
   } map_job_type;

endpackage

[rtl/core/rim_if.sv]
interface rim_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic [rim_pkg::ENTRY_W-1:0]  entry_index;
   logic [rim_pkg::CNT_W-1:0]    repeat_count;
   logic [rim_pkg::FIELD_W-1:0]  input_address;

   modport source (output valid, command, entry_index, repeat_count, input_address,
                   input ready);
   modport sink (input valid, command, entry_index, repeat_count, input_address,
                 output ready);
endinterface

interface rim_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rim_pkg::FIELD_W-1:0]  output_address;
   logic [rim_pkg::FIELD_W-1:0]  source_address;
   logic                         last_copy;
   logic                         map_error;

   modport source (output valid, output_address, source_address, last_copy, map_error,
                   input ready);
   modport sink (input valid, output_address, source_address, last_copy, map_error,
                 output ready);
endinterface

[rtl/core/repeat_interleave_address_map_core.sv]
// Repeat-interleave address map.
// req channel: command 0 loads one repeat table entry (entry_index, repeat_count),
//   loads in ascending order, index 0 restarts the table; command 1 maps input_address.
// rsp channel: one beat per copy (output_address, source_address, last_copy), or a
//   single beat with map_error set for a bad address or an unloaded axis position.
//   A position with repeat count zero gives no beat.
// csr port: sizes of the four dimensions (index 0..3) and the repeat axis (index 4),
//   written while idle.
// Timing: a map passes the front end as four size multiplies, four 32-step divisions
//   in the shared bit-serial divider, a table read and four multiply-accumulate
//   steps. Its beats then leave the back end at one per cycle while the receiver
//   is ready; a two-entry job queue lets the next map be decoded meanwhile.
// Reset clears the table fill count and running total, sets all sizes to 1 and the
//   axis to 0; table contents are not cleared.
// A stalled receiver holds the current beat; the back end and then the queue and the
//   front end back up in turn.
module repeat_interleave_address_map_core #(
   parameter int unsigned MAX_AXIS_LEN = rim_pkg::DEF_MAX_AXIS_LEN,
   parameter int unsigned MAX_REPEAT   = rim_pkg::DEF_MAX_REPEAT,
   parameter int unsigned NUM_DIMS     = rim_pkg::DEF_NUM_DIMS,
   parameter int unsigned ADDR_WIDTH   = rim_pkg::DEF_ADDR_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   rim_req_if.sink                         req,
   rim_rsp_if.source                       rsp,
   input  logic                            csr_we,
   input  logic [rim_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rim_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import rim_pkg::*;

   cfg_type     cfg_ff;
   map_job_type fj;
   logic        fj_valid;
   logic        fj_ready;
   map_job_type bj;
   logic        bj_valid;
   logic        bj_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size <= {4{SIZE_W'(1)}};
         cfg_ff.axis <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SIZE_DIM0:   cfg_ff.size[0] <= csr_wdata[SIZE_W-1:0];
            CSR_SIZE_DIM1:   cfg_ff.size[1] <= csr_wdata[SIZE_W-1:0];
            CSR_SIZE_DIM2:   cfg_ff.size[2] <= csr_wdata[SIZE_W-1:0];
            CSR_SIZE_DIM3:   cfg_ff.size[3] <= csr_wdata[SIZE_W-1:0];
            CSR_REPEAT_AXIS: cfg_ff.axis    <= csr_wdata[AXIS_W-1:0];
            default: ;
         endcase
      end
   end

   rim_front #(
      .MAX_AXIS_LEN (MAX_AXIS_LEN),
      .MAX_REPEAT   (MAX_REPEAT),
      .NUM_DIMS     (NUM_DIMS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cfg       (cfg_ff),
      .job       (fj),
      .job_valid (fj_valid),
      .job_ready (fj_ready)
   );

   rim_fifo #(.DEPTH(2)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_data  (fj),
      .wr_valid (fj_valid),
      .wr_ready (fj_ready),
      .rd_data  (bj),
      .rd_valid (bj_valid),
      .rd_ready (bj_ready)
   );

   rim_back #(.ADDR_WIDTH(ADDR_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (bj),
      .job_valid (bj_valid),
      .job_ready (bj_ready),
      .rsp       (rsp)
   );
endmodule

[rtl/core/rim_divider.sv]
module rim_divider #(
   parameter int unsigned DIVIDEND_W = 32,
   parameter int unsigned DIVISOR_W  = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);
   localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [STEP_W-1:0]     step_ff;
   logic                  run_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= STEP_W'(DIVIDEND_W);
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (run_ff) begin
            rem_ff  <= fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : trial[DIVISOR_W-1:0];
            quo_ff  <= {quo_ff[DIVIDEND_W-2:0], fits};
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

[rtl/core/rim_front.sv]
module rim_front #(
   parameter int unsigned MAX_AXIS_LEN = rim_pkg::DEF_MAX_AXIS_LEN,
   parameter int unsigned MAX_REPEAT   = rim_pkg::DEF_MAX_REPEAT,
   parameter int unsigned NUM_DIMS     = rim_pkg::DEF_NUM_DIMS,
   parameter int unsigned ADDR_WIDTH   = rim_pkg::DEF_ADDR_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   rim_req_if.sink              req,
   input  rim_pkg::cfg_type     cfg,
   output rim_pkg::map_job_type job,
   output logic                 job_valid,
   input  logic                 job_ready
);
   import rim_pkg::*;

   localparam int unsigned TBL_AW = (MAX_AXIS_LEN > 1) ? $clog2(MAX_AXIS_LEN) : 1;
   localparam int unsigned ENT_W  = $clog2(MAX_AXIS_LEN + 1);
   localparam int unsigned OW     = (ADDR_WIDTH < FIELD_W) ? ADDR_WIDTH : FIELD_W;
   localparam int unsigned TOT_W  = FIELD_W + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_TOT, S_CHK, S_DIV_GO, S_DIV_WAIT, S_READ, S_LOOK, S_MAC
   } state_type;

   state_type                  state_ff;
   logic                       push_ff;
   map_job_type                job_ff;
   logic [CNT_W+OFS_W-1:0]     tbl_mem [MAX_AXIS_LEN];
   logic [CNT_W+OFS_W-1:0]     rd_ff;
   logic [OFS_W-1:0]           total_ff;
   logic [ENT_W-1:0]           entries_ff;
   logic [FIELD_W-1:0]         addr_ff;
   logic [FIELD_W-1:0]         rem_ff;
   logic [TOT_W-1:0]           tot_ff;
   logic [1:0]                 dim_ff;
   logic [3:0][SIZE_W-1:0]     idx_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [OFS_W-1:0]           ofs_ff;
   logic [OW-1:0]              oa_ff;
   logic [OW-1:0]              acc_ff;
   logic [OW-1:0]              stride_ff;

   logic [3:0][SIZE_W-1:0]     sz;
   logic                       accept;
   logic                       load_ok;
   logic [CNT_W-1:0]           cnt_sat;
   logic [OFS_W-1:0]           ofs_new;
   logic [TOT_W+SIZE_W-1:0]    tot_prod;
   logic                       addr_over;
   logic                       div_start;
   logic                       div_done;
   logic [FIELD_W-1:0]         div_quo;
   logic [SIZE_W-1:0]          div_rem;
   logic                       is_ax;
   logic [OFS_W-1:0]           mac_idx;
   logic [OFS_W-1:0]           mac_size;
   logic [OW+OFS_W-1:0]        prod_oa;
   logic [OW+OFS_W-1:0]        prod_acc;

   always_comb begin
      for (int d = 0; d < 4; d++) begin
         sz[d] = (d < 4 - int'(NUM_DIMS)) ? SIZE_W'(1) : cfg.size[d];
      end
      accept    = req.valid && req.ready;
      load_ok   = (32'(req.entry_index) < MAX_AXIS_LEN) &&
                  ((req.entry_index == '0) || (32'(req.entry_index) == 32'(entries_ff)));
      cnt_sat   = (32'(req.repeat_count) > MAX_REPEAT) ? CNT_W'(MAX_REPEAT) : req.repeat_count;
      ofs_new   = (req.entry_index == '0) ? '0 : total_ff;
      tot_prod  = tot_ff * sz[dim_ff];
      addr_over = (ADDR_WIDTH < FIELD_W) ? ((TOT_W'(addr_ff) >> ADDR_WIDTH) != '0) : 1'b0;
      div_start = state_ff == S_DIV_GO;
      is_ax     = dim_ff == cfg.axis;
      mac_idx   = is_ax ? ofs_ff : OFS_W'(idx_ff[dim_ff]);
      mac_size  = is_ax ? total_ff : OFS_W'(sz[dim_ff]);
      prod_oa   = mac_idx * acc_ff;
      prod_acc  = mac_size * acc_ff;
   end

   rim_divider #(.DIVIDEND_W(FIELD_W), .DIVISOR_W(SIZE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rem_ff),
      .divisor   (sz[dim_ff]),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (accept && req.command == CMD_LOAD && load_ok) begin
         tbl_mem[TBL_AW'(req.entry_index)] <= {cnt_sat, ofs_new};
      end
      rd_ff <= tbl_mem[TBL_AW'(idx_ff[cfg.axis])];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         push_ff    <= 1'b0;
         total_ff   <= '0;
         entries_ff <= '0;
      end else begin
         if (push_ff && job_ready) begin
            push_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req.command == CMD_LOAD) begin
                     if (load_ok) begin
                        total_ff   <= OFS_W'(ofs_new + OFS_W'(cnt_sat));
                        entries_ff <= ENT_W'(ENT_W'(req.entry_index) + 1'b1);
                     end
                  end else begin
                     addr_ff  <= req.input_address;
                     tot_ff   <= TOT_W'(1);
                     dim_ff   <= 2'd0;
                     state_ff <= S_TOT;
                  end
               end
            end
            S_TOT: begin
               tot_ff <= (tot_prod > (TOT_W+SIZE_W)'(33'h1_0000_0000)) ?
                         TOT_W'(33'h1_0000_0000) : tot_prod[TOT_W-1:0];
               dim_ff <= dim_ff + 1'b1;
               if (dim_ff == 2'd3) begin
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if ((TOT_W'(addr_ff) >= tot_ff) || addr_over) begin
                  job_ff   <= '{base: '0, stride: '0, count: CNT_W'(1),
                                source: addr_ff, err: 1'b1};
                  push_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  rem_ff   <= addr_ff;
                  dim_ff   <= 2'd3;
                  state_ff <= S_DIV_GO;
               end
            end
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  idx_ff[dim_ff] <= div_rem;
                  rem_ff         <= div_quo;
                  if (dim_ff == 2'd0) begin
                     state_ff <= S_READ;
                  end else begin
                     dim_ff   <= dim_ff - 1'b1;
                     state_ff <= S_DIV_GO;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_LOOK;
            end
            S_LOOK: begin
               if (32'(idx_ff[cfg.axis]) >= 32'(entries_ff)) begin
                  job_ff   <= '{base: '0, stride: '0, count: CNT_W'(1),
                                source: addr_ff, err: 1'b1};
                  push_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff    <= rd_ff[CNT_W+OFS_W-1:OFS_W];
                  ofs_ff    <= rd_ff[OFS_W-1:0];
                  oa_ff     <= '0;
                  acc_ff    <= OW'(1);
                  stride_ff <= OW'(1);
                  dim_ff    <= 2'd3;
                  state_ff  <= S_MAC;
               end
            end
            S_MAC: begin
               oa_ff  <= OW'(oa_ff + prod_oa[OW-1:0]);
               acc_ff <= prod_acc[OW-1:0];
               if (is_ax) begin
                  stride_ff <= acc_ff;
               end
               dim_ff <= dim_ff - 1'b1;
               if (dim_ff == 2'd0) begin
                  job_ff   <= '{base: FIELD_W'(OW'(oa_ff + prod_oa[OW-1:0])),
                                stride: FIELD_W'(is_ax ? acc_ff : stride_ff),
                                count: cnt_ff, source: addr_ff, err: 1'b0};
                  push_ff  <= cnt_ff != '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready = (state_ff == S_IDLE) && !push_ff;
   assign job       = job_ff;
   assign job_valid = push_ff;
endmodule

[rtl/core/rim_fifo.sv]
module rim_fifo #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rim_pkg::map_job_type wr_data,
   input  logic                 wr_valid,
   output logic                 wr_ready,
   output rim_pkg::map_job_type rd_data,
   output logic                 rd_valid,
   input  logic                 rd_ready
);
   import rim_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   map_job_type     slot_ff [DEPTH];
   logic [PW-1:0]   wp_ff;
   logic [PW-1:0]   rp_ff;
   logic [CW-1:0]   fill_ff;
   logic            do_wr;
   logic            do_rd;

   assign wr_ready = fill_ff != CW'(DEPTH);
   assign rd_valid = fill_ff != '0;
   assign rd_data  = slot_ff[rp_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wp_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (do_wr) begin
            wp_ff <= (32'(wp_ff) == DEPTH - 1) ? '0 : PW'(wp_ff + 1'b1);
         end
         if (do_rd) begin
            rp_ff <= (32'(rp_ff) == DEPTH - 1) ? '0 : PW'(rp_ff + 1'b1);
         end
         fill_ff <= CW'(fill_ff + CW'(do_wr) - CW'(do_rd));
      end
   end
endmodule

[rtl/core/rim_back.sv]
module rim_back #(
   parameter int unsigned ADDR_WIDTH = rim_pkg::DEF_ADDR_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rim_pkg::map_job_type job,
   input  logic                 job_valid,
   output logic                 job_ready,
   rim_rsp_if.source            rsp
);
   import rim_pkg::*;

   localparam logic [FIELD_W-1:0] ADDR_MASK = (ADDR_WIDTH >= FIELD_W) ? '1 :
                                              FIELD_W'((64'd1 << ADDR_WIDTH) - 64'd1);

   logic               active_ff;
   logic [FIELD_W-1:0] addr_ff;
   logic [FIELD_W-1:0] stride_ff;
   logic [CNT_W-1:0]   left_ff;
   logic [FIELD_W-1:0] src_ff;
   logic               err_ff;
   logic               vld_ff;
   logic [FIELD_W-1:0] oa_ff;
   logic [FIELD_W-1:0] sa_ff;
   logic               last_ff;
   logic               merr_ff;
   logic               out_free;

   assign out_free  = !vld_ff || rsp.ready;
   assign job_ready = !active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         vld_ff    <= 1'b0;
      end else begin
         if (!active_ff) begin
            if (job_valid) begin
               active_ff <= 1'b1;
               addr_ff   <= job.base;
               stride_ff <= job.stride;
               left_ff   <= job.count;
               src_ff    <= job.source;
               err_ff    <= job.err;
            end
         end
         if (out_free) begin
            vld_ff <= active_ff;
            if (active_ff) begin
               oa_ff     <= addr_ff;
               sa_ff     <= src_ff;
               last_ff   <= left_ff == CNT_W'(1);
               merr_ff   <= err_ff;
               addr_ff   <= (addr_ff + stride_ff) & ADDR_MASK;
               left_ff   <= left_ff - 1'b1;
               if (left_ff == CNT_W'(1)) begin
                  active_ff <= 1'b0;
               end
            end
         end
      end
   end

   assign rsp.valid          = vld_ff;
   assign rsp.output_address = oa_ff;
   assign rsp.source_address = sa_ff;
   assign rsp.last_copy      = last_ff;
   assign rsp.map_error      = merr_ff;
endmodule

[rtl/core/rim_checker.sv]
module rim_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_output_address,
   input logic [31:0] rsp_source_address,
   input logic        rsp_last_copy,
   input logic        rsp_map_error
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_output_address) &&
      $stable(rsp_source_address) && $stable(rsp_last_copy) && $stable(rsp_map_error))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_map_error |-> rsp_last_copy)
      else $error("error beat without last mark");

   a_err_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_map_error |-> rsp_output_address == 32'd0)
      else $error("error beat with nonzero output address");
endmodule

bind repeat_interleave_address_map_core rim_checker u_rim_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_output_address (rsp.output_address),
   .rsp_source_address (rsp.source_address),
   .rsp_last_copy      (rsp.last_copy),
   .rsp_map_error      (rsp.map_error)
);

[bench/repeat_interleave_address_map_core_tb.sv]
`timescale 1ns / 1ps

module repeat_interleave_address_map_core_tb;
   import rim_pkg::*;

   typedef struct packed {
      logic        command;
      logic [7:0]  entry_index;
      logic [6:0]  repeat_count;
      logic [31:0] input_address;
   } req_beat_type;

   typedef struct packed {
      logic [31:0] output_address;
      logic [31:0] source_address;
      logic        last_copy;
      logic        map_error;
   } copy_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   rim_req_if req();
   rim_rsp_if rsp();

   repeat_interleave_address_map_core dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [12:0] dim_len [4];
   logic [1:0]  rep_axis;
   logic [6:0]  copies_at [256];
   logic [14:0] start_at [256];
   logic [14:0] axis_total;
   logic [8:0]  fill_count;

   req_beat_type  pending_beats [$];
   copy_beat_type expected_copies [$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int sent_beats = 0;

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic add_copy(input copy_beat_type c);
      expected_copies.insert(expected_copies.size(), c);
   endtask

   task automatic add_beat(input req_beat_type b);
      pending_beats.insert(pending_beats.size(), b);
   endtask

   task automatic predict_copies(input req_beat_type b);
      logic [63:0] sz [4];
      logic [63:0] ix [4];
      logic [63:0] total, rem, oa, acc, ostride;
      logic [6:0] cnt;
      copy_beat_type c;
      if (b.command == CMD_LOAD) begin
         logic [6:0] k;
         if (b.entry_index != 0 && {1'b0, b.entry_index} != fill_count) return;
         if (b.entry_index == 0) axis_total = '0;
         k = (b.repeat_count > 64) ? 7'd64 : b.repeat_count;
         copies_at[b.entry_index] = k;
         start_at[b.entry_index] = axis_total;
         axis_total = axis_total + 15'(k);
         fill_count = 9'(b.entry_index) + 9'd1;
         return;
      end
      total = 1;
      for (int d = 0; d < 4; d++) begin
         sz[d] = 64'(dim_len[d]);
         total = total * sz[d];
      end
      c.source_address = b.input_address;
      c.output_address = '0;
      c.last_copy = 1'b1;
      c.map_error = 1'b1;
      if (total == 0 || {32'd0, b.input_address} >= total) begin
         add_copy(c);
         return;
      end
      rem = 64'(b.input_address);
      for (int d = 3; d >= 0; d--) begin
         ix[d] = rem % sz[d];
         rem = rem / sz[d];
      end
      if (ix[rep_axis] >= 64'(fill_count)) begin
         add_copy(c);
         return;
      end
      cnt = copies_at[ix[rep_axis][7:0]];
      ix[rep_axis] = 64'(start_at[ix[rep_axis][7:0]]);
      sz[rep_axis] = 64'(axis_total);
      oa = 0;
      acc = 1;
      ostride = 1;
      for (int d = 3; d >= 0; d--) begin
         if (d == rep_axis) ostride = acc;
         oa = oa + ix[d] * acc;
         acc = acc * sz[d];
      end
      for (int t = 0; t < cnt; t++) begin
         c.output_address = 32'(oa + 64'(t) * ostride);
         c.last_copy = (t + 1 == cnt);
         c.map_error = 1'b0;
         add_copy(c);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (req.valid) begin
            predict_copies({req.command, req.entry_index, req.repeat_count,
                            req.input_address});
            sent_beats++;
         end
         if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_beat_type b;
            b = pending_beats.pop_front();
            req.valid <= 1'b1;
            req.command <= b.command;
            req.entry_index <= b.entry_index;
            req.repeat_count <= b.repeat_count;
            req.input_address <= b.input_address;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            copy_beat_type e;
            if (expected_copies.size() == 0) begin
               report($sformatf("unexpected beat oa=%h sa=%h", rsp.output_address,
                                rsp.source_address));
            end else begin
               e = expected_copies.pop_front();
               if (rsp.output_address !== e.output_address)
                  report($sformatf("output_address %h exp %h", rsp.output_address,
                                   e.output_address));
               if (rsp.source_address !== e.source_address)
                  report($sformatf("source_address %h exp %h", rsp.source_address,
                                   e.source_address));
               if (rsp.last_copy !== e.last_copy)
                  report($sformatf("last_copy %b exp %b", rsp.last_copy, e.last_copy));
               if (rsp.map_error !== e.map_error)
                  report($sformatf("map_error %b exp %b", rsp.map_error, e.map_error));
            end
         end
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      req.valid = 1'b0;
      req.command = CMD_LOAD;
      req.entry_index = '0;
      req.repeat_count = '0;
      req.input_address = '0;
      rsp.ready = 1'b0;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DAT_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_REPEAT_AXIS) rep_axis = val[1:0];
      else dim_len[idx[1:0]] = val[12:0];
   endtask

   task automatic set_shape(input int s0, s1, s2, s3, ax);
      write_reg(CSR_SIZE_DIM0, s0);
      write_reg(CSR_SIZE_DIM1, s1);
      write_reg(CSR_SIZE_DIM2, s2);
      write_reg(CSR_SIZE_DIM3, s3);
      write_reg(CSR_REPEAT_AXIS, ax);
   endtask

   task automatic queue_load(input int e, input int c);
      req_beat_type b;
      b.command = CMD_LOAD;
      b.entry_index = 8'(e);
      b.repeat_count = 7'(c);
      b.input_address = $urandom;
      add_beat(b);
   endtask

   task automatic queue_map(input logic [31:0] a);
      req_beat_type b;
      b.command = CMD_MAP;
      b.entry_index = 8'($urandom);
      b.repeat_count = 7'($urandom);
      b.input_address = a;
      add_beat(b);
   endtask

   task automatic drain;
      while (pending_beats.size() > 0 || req.valid || expected_copies.size() > 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [6:0] rand_count;
      case ($urandom_range(9))
         0: return 7'd0;
         1: return 7'd64;
         2: return 7'($urandom_range(127, 65));
         default: return 7'($urandom_range(6, 1));
      endcase
   endfunction

   // one random phase: table of n entries along the axis, then maps
   task automatic random_phase(input int maps, input int axis_len, input int tensor);
      int n;
      n = $urandom_range(axis_len, 1);
      for (int e = 0; e < n; e++) begin
         if ($urandom_range(9) == 0) queue_load($urandom_range(255, n + 1), rand_count());
         queue_load(e, rand_count());
      end
      for (int i = 0; i < maps; i++) begin
         if ($urandom_range(9) == 0) queue_map($urandom);
         else queue_map($urandom_range(tensor - 1));
      end
   endtask

   initial begin
      for (int d = 0; d < 4; d++) dim_len[d] = 13'd1;
      rep_axis = 0;
      axis_total = 0;
      fill_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed
      send_idle_pct = 29;
      recv_idle_pct = 54;
      queue_map(32'd0);
      drain();
      set_shape(2, 3, 4, 5, 1);
      queue_load(0, 2);
      queue_load(2, 5);
      queue_load(1, 0);
      queue_load(2, 127);
      queue_map(32'd0);
      queue_map(32'd20);
      queue_map(32'd45);
      queue_map(32'd60);
      queue_map(32'd119);
      queue_map(32'd120);
      queue_map(32'hFFFF_FFFF);
      queue_load(0, 1);
      queue_map(32'd45);
      queue_map(32'd0);
      queue_load(255, 3);
      drain();

      set_shape(0, 3, 4, 5, 3);
      queue_map(32'd0);
      queue_map(32'd7);
      drain();

      set_shape(4096, 4096, 1, 1, 2);
      queue_load(0, 64);
      queue_map(32'hFFFF_FFFF);
      queue_map(32'h00FF_FFFF);
      queue_map(32'h0123_4567);
      drain();

      set_shape(1, 1, 1, 8, 3);
      for (int e = 0; e < 8; e++) queue_load(e, (e == 7) ? 3 : 0);
      queue_map(32'd7);
      queue_map(32'd6);
      drain();

      // random
      set_shape(3, 4, 5, 6, 2);
      random_phase(22, 5, 360);
      drain();

      send_idle_pct = 54;
      recv_idle_pct = 29;
      set_shape(7, 9, 2, 3, 0);
      random_phase(22, 7, 378);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_shape(2, 2, 2, 1, 3);
      random_phase(5, 1, 8);
      drain();
      set_shape(16, 4096, 2, 4096, 1);
      random_phase(15, 20, 32'h7FFF_FFFF);
      drain();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
rtl/core/rim_pkg.sv
rtl/core/rim_if.sv
rtl/core/rim_divider.sv
rtl/core/rim_front.sv
rtl/core/rim_fifo.sv
rtl/core/rim_back.sv
rtl/core/repeat_interleave_address_map_core.sv
rtl/core/rim_checker.sv
bench/repeat_interleave_address_map_core_tb.sv
